FILE: hdl/kmer_histogram_counter_assert.svh
// Assertion macros shared by the k-mer histogram counter RTL.
`ifndef KMER_HISTOGRAM_COUNTER_ASSERT_SVH
`define KMER_HISTOGRAM_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define KHC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KHC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define KHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/khc_pkg.sv
// Package with types, constants and helper functions of the k-mer histogram counter.
`timescale 1ns / 1ps
`default_nettype none
package khc_pkg;

  localparam int unsigned MAX_K_DEF      = 10;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam logic [3:0]  KLEN_RESET  = 4'd10;
  localparam logic [7:0]  START_RESET = 8'd2;
  localparam logic [31:0] MIN_RESET   = 32'd0;
  localparam logic [8:0]  POS_MAX     = 9'd511;

  localparam logic [1:0] CFG_KMER_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_START_POSITION = 2'd1;
  localparam logic [1:0] CFG_MIN_COUNT      = 2'd2;

  localparam logic REQ_BASE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_UPDATE,
    ST_RESPOND
  } khc_state_e;

  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic exec;
    logic update;
    logic respond;
  } khc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic window_hit;
  } khc_status_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    case (ch)
      8'h43, 8'h63: code = CODE_C;
      8'h47, 8'h67: code = CODE_G;
      8'h54, 8'h74: code = CODE_T;
      default:      code = CODE_A;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/khc_ram.sv
// Generic memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module khc_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/khc_ctrl.sv
// Controller state machine that sequences clearing, base updates and queries.
`timescale 1ns / 1ps
`default_nettype none
module khc_ctrl
  import khc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire khc_status_t status_i,
  output khc_cmd_t         cmd_o,
  output logic             busy_o
);

  khc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.is_query) begin
          state_d = ST_RESPOND;
        end else if (status_i.window_hit) begin
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE:  state_d = ST_IDLE;
      ST_RESPOND: state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clear_wr = 1'b1;
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ST_EXEC:    cmd_o.exec    = 1'b1;
      ST_UPDATE:  cmd_o.update  = 1'b1;
      ST_RESPOND: cmd_o.respond = 1'b1;
      default:    busy_o        = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/khc_datapath.sv
// Datapath with configuration, read window, count store access and result registers.
`timescale 1ns / 1ps
`default_nettype none
module khc_datapath
  import khc_pkg::*;
#(
  parameter int unsigned MAX_K      = MAX_K_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire khc_cmd_t    cmd_i,
  output khc_status_t      status_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  base_char_i,
  input  wire logic        first_of_read_i,
  input  wire logic [19:0] query_index_i,
  input  wire logic        cfg_wr_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [31:0]      entry_count_o,
  output logic             meets_threshold_o,
  output logic [31:0]      kmers_counted_o
);

  localparam int unsigned ADDR_W = 2 * MAX_K;
  localparam logic [4:0]  MAX_K_V = 5'(MAX_K);

  logic [3:0]  klen_q;
  logic [7:0]  start_q;
  logic [31:0] min_q;

  logic        req_q;
  logic [7:0]  char_q;
  logic        first_q;
  logic [19:0] qidx_q;

  logic [8:0]        pos_q, pos_d;
  logic [ADDR_W-1:0] win_q, win_d;
  logic [ADDR_W-1:0] addr_q;
  logic [31:0]       total_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic        done_q;
  logic [31:0] entry_q;
  logic        meets_q;
  logic [31:0] out_total_q;

  logic [4:0]            k_eff;
  logic [7:0]            start_eff;
  logic [8:0]            last_pos;
  logic [ADDR_W-1:0]     kmask;
  logic [ADDR_W+1:0]     win_shift;
  logic [1:0]            code;
  logic                  hit;
  logic [ADDR_W-1:0]     raddr;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] count_inc;
  logic [31:0]           rdata_ext;

  always_comb begin
    if (klen_q == 4'd0) begin
      k_eff = 5'd1;
    end else if ({1'b0, klen_q} > MAX_K_V) begin
      k_eff = MAX_K_V;
    end else begin
      k_eff = {1'b0, klen_q};
    end
    start_eff = (start_q == 8'd0) ? 8'd1 : start_q;
    last_pos  = 9'(start_eff) + 9'(k_eff) - 9'd1;
    for (int i = 0; i < ADDR_W; i++) begin
      kmask[i] = (i < 2 * int'(k_eff));
    end
  end

  always_comb begin
    code = base_code(char_q);
    if (first_q) begin
      pos_d = 9'd1;
    end else if (pos_q < POS_MAX) begin
      pos_d = pos_q + 9'd1;
    end else begin
      pos_d = pos_q;
    end
    win_shift = {win_q, code};
    if (pos_d == 9'(start_eff)) begin
      win_d = ADDR_W'(code);
    end else if (pos_d > 9'(start_eff) && pos_d <= last_pos) begin
      win_d = win_shift[ADDR_W-1:0];
    end else begin
      win_d = win_q;
    end
    hit = (pos_d == last_pos);
  end

  assign raddr = (req_q == REQ_QUERY) ? (ADDR_W'(qidx_q) & kmask) : (win_d & kmask);

  assign count_inc = (rdata == '1) ? rdata : rdata + COUNT_BITS'(1);
  assign we        = cmd_i.clear_wr | cmd_i.update;
  assign waddr     = cmd_i.clear_wr ? clr_addr_q : addr_q;
  assign wdata     = cmd_i.clear_wr ? '0 : count_inc;
  assign rdata_ext = 32'(rdata);

  khc_ram #(
    .WIDTH  (COUNT_BITS),
    .ADDR_W (ADDR_W)
  ) u_count_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.exec),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= KLEN_RESET;
      start_q <= START_RESET;
      min_q   <= MIN_RESET;
    end else if (cfg_wr_i) begin
      case (cfg_index_i)
        CFG_KMER_LENGTH:    klen_q  <= cfg_data_i[3:0];
        CFG_START_POSITION: start_q <= cfg_data_i[7:0];
        CFG_MIN_COUNT:      min_q   <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      win_q      <= '0;
      total_q    <= '0;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.respond;
      if (cmd_i.clear_wr) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.exec && req_q == REQ_BASE) begin
        pos_q <= pos_d;
        win_q <= win_d;
      end
      if (cmd_i.update && total_q != '1) begin
        total_q <= total_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      char_q  <= base_char_i;
      first_q <= first_of_read_i;
      qidx_q  <= query_index_i;
    end
    if (cmd_i.exec) begin
      addr_q <= raddr;
    end
    if (cmd_i.respond) begin
      entry_q     <= rdata_ext;
      meets_q     <= (rdata_ext >= min_q);
      out_total_q <= total_q;
    end
  end

  assign status_o.clear_last = &clr_addr_q;
  assign status_o.is_query   = (req_q == REQ_QUERY);
  assign status_o.window_hit = hit;

  assign done_o            = done_q;
  assign entry_count_o     = entry_q;
  assign meets_threshold_o = meets_q;
  assign kmers_counted_o   = out_total_q;

endmodule
`default_nettype wire

FILE: hdl/kmer_histogram_counter.sv
// Top level of the k-mer histogram counter: controller, datapath and checks.
//
// Items enter on start_i while busy_o is low. A base item (req_type_i low) carries one
// read character and a first-of-read flag; a query item (req_type_i high) carries the
// packed k-mer in query_index_i. A base item passes through capture and execute, and
// through update when it closes the counting window and the counter read-modify-write
// runs through the count store. A query item goes through capture, execute and respond.
// The result shows on entry_count_o, meets_threshold_o and kmers_counted_o for one
// cycle with done_o high as busy_o falls. The count store's ports set these steps.
// Configuration transactions on cfg_valid_i/cfg_index_i/cfg_data_i are always taken
// (cfg_ready_o is high) and belong to idle periods between items.
// After reset the block clears all 4**MAX_K count store entries (1048576 at the default),
// one entry per cycle, with busy_o high; configuration is taken during that time.
// The receiver cannot stall: every result is valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_histogram_counter_assert.svh"
module kmer_histogram_counter
  import khc_pkg::*;
#(
  parameter int unsigned MAX_K      = MAX_K_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  base_char_i,
  input  wire logic        first_of_read_i,
  input  wire logic [19:0] query_index_i,
  output logic             done_o,
  output logic [31:0]      entry_count_o,
  output logic             meets_threshold_o,
  output logic [31:0]      kmers_counted_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  khc_cmd_t    cmd;
  khc_status_t status;

  assign cfg_ready_o = 1'b1;

  khc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  khc_datapath #(
    .MAX_K      (MAX_K),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_type_i        (req_type_i),
    .base_char_i       (base_char_i),
    .first_of_read_i   (first_of_read_i),
    .query_index_i     (query_index_i),
    .cfg_wr_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .entry_count_o     (entry_count_o),
    .meets_threshold_o (meets_threshold_o),
    .kmers_counted_o   (kmers_counted_o)
  );

  `KHC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `KHC_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `KHC_ASSERT_NEXT(a_respond_done, clk_i, rst_ni, cmd.respond, done_o && !busy_o)
  `KHC_ASSERT_SAME(a_single_port, clk_i, rst_ni, cmd.exec, !cmd.update && !cmd.clear_wr)

endmodule
`default_nettype wire

FILE: test/kmer_tally_checker.sv
`timescale 1ns / 1ps
// Checker that mirrors the k-mer histogram counter and compares every query result it sees.
module kmer_tally_checker
  import khc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  base_char_i,
  input  wire logic        first_of_read_i,
  input  wire logic [19:0] query_index_i,
  input  wire logic        done_i,
  input  wire logic [31:0] entry_count_i,
  input  wire logic        meets_threshold_i,
  input  wire logic [31:0] kmers_counted_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               outstanding_o
);

  typedef struct packed {
    logic [31:0] entry_count;
    logic        meets_threshold;
    logic [31:0] kmers_counted;
  } tally_t;

  logic [3:0]  kmer_len_q;
  logic [7:0]  start_pos_q;
  logic [31:0] min_count_q;
  bit   [31:0] count_mem [0:(1 << 20) - 1];
  logic [19:0] window_q;
  logic [8:0]  position_q;
  logic [31:0] total_q;
  tally_t      tally_q [$];
  int          fails;

  always @(posedge clk_i or negedge rst_ni) begin : mirror
    int          i;
    int          k;
    int          first_pos;
    int          last_pos;
    logic [19:0] kmask;
    logic [19:0] slot;
    logic [1:0]  code;
    tally_t      want;
    tally_t      got;
    if (!rst_ni) begin
      kmer_len_q  = KLEN_RESET;
      start_pos_q = START_RESET;
      min_count_q = MIN_RESET;
      for (i = 0; i < (1 << 20); i++) count_mem[i] = '0;
      window_q   = '0;
      position_q = '0;
      total_q    = '0;
      tally_q.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KMER_LENGTH:    kmer_len_q = cfg_data_i[3:0];
          CFG_START_POSITION: start_pos_q = cfg_data_i[7:0];
          CFG_MIN_COUNT:      min_count_q = cfg_data_i;
          default: ;
        endcase
      end

      if (done_i) begin
        got = {entry_count_i, meets_threshold_i, kmers_counted_i};
        if (tally_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected query result: count %0d meets %0d total %0d",
                     got.entry_count, got.meets_threshold, got.kmers_counted);
          end
        end else begin
          want = tally_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("query mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.entry_count, want.meets_threshold, want.kmers_counted,
                       got.entry_count, got.meets_threshold, got.kmers_counted);
            end
          end
        end
      end

      if (start_i && !busy_i) begin
        k = (kmer_len_q == 0) ? 1 : (kmer_len_q > MAX_K_DEF) ? MAX_K_DEF : kmer_len_q;
        kmask = 20'((1 << (2 * k)) - 1);
        if (req_type_i == REQ_QUERY) begin
          slot = query_index_i & kmask;
          want = {count_mem[slot], (count_mem[slot] >= min_count_q), total_q};
          tally_q.insert(tally_q.size(), want);
        end else begin
          first_pos = (start_pos_q == 0) ? 1 : start_pos_q;
          last_pos  = first_pos + k - 1;
          case (base_char_i)
            "C", "c": code = CODE_C;
            "G", "g": code = CODE_G;
            "T", "t": code = CODE_T;
            default:  code = CODE_A;
          endcase
          if (first_of_read_i) position_q = 9'd1;
          else if (position_q < POS_MAX) position_q = position_q + 9'd1;
          if (position_q == first_pos) begin
            window_q = {18'd0, code};
          end else if (position_q > first_pos && position_q <= last_pos) begin
            window_q = {window_q[17:0], code};
          end
          if (position_q == last_pos) begin
            slot = window_q & kmask;
            if (count_mem[slot] != '1) count_mem[slot] = count_mem[slot] + 32'd1;
            if (total_q != '1) total_q = total_q + 32'd1;
          end
        end
      end

      fail_count_o  <= fails;
      outstanding_o <= tally_q.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top that feeds reads, queries and settings to the k-mer histogram counter.
module tb_top;
  import khc_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int READ_POOL = 4;
  localparam int POOL_LEN  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [7:0]  base_char_i;
  logic        first_of_read_i;
  logic [19:0] query_index_i;
  logic        done_o;
  logic [31:0] entry_count_o;
  logic        meets_threshold_o;
  logic [31:0] kmers_counted_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int          fail_count;
  int          outstanding;
  int          idle_pct;
  int          items_sent;
  logic [3:0]  cur_k;
  logic [7:0]  cur_start;
  logic [1:0]  pool_codes [0:READ_POOL-1][0:POOL_LEN-1];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  kmer_histogram_counter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .req_type_i        (req_type_i),
    .base_char_i       (base_char_i),
    .first_of_read_i   (first_of_read_i),
    .query_index_i     (query_index_i),
    .done_o            (done_o),
    .entry_count_o     (entry_count_o),
    .meets_threshold_o (meets_threshold_o),
    .kmers_counted_o   (kmers_counted_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  kmer_tally_checker tally_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .req_type_i        (req_type_i),
    .base_char_i       (base_char_i),
    .first_of_read_i   (first_of_read_i),
    .query_index_i     (query_index_i),
    .done_i            (done_o),
    .entry_count_i     (entry_count_o),
    .meets_threshold_i (meets_threshold_o),
    .kmers_counted_i   (kmers_counted_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding)
  );

  function automatic int active_k();
    return (cur_k == 0) ? 1 : (cur_k > MAX_K_DEF) ? MAX_K_DEF : cur_k;
  endfunction

  function automatic int active_start();
    return (cur_start == 0) ? 1 : cur_start;
  endfunction

  task automatic send_item(input logic req, input logic [7:0] ch, input logic first,
                           input logic [19:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    req_type_i      <= req;
    base_char_i     <= ch;
    first_of_read_i <= first;
    query_index_i   <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic quiesce();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_setting(input logic [3:0] k, input logic [7:0] st,
                                 input logic [31:0] minc);
    logic [31:0] data [0:3];
    logic [1:0]  index [0:3];
    int          i;
    index[0] = CFG_SPARE;
    index[1] = CFG_KMER_LENGTH;
    index[2] = CFG_START_POSITION;
    index[3] = CFG_MIN_COUNT;
    data[0]  = $urandom;
    data[1]  = {28'($urandom), k};
    data[2]  = {24'($urandom), st};
    data[3]  = minc;
    for (i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= index[i];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_k     = k;
    cur_start = st;
  endtask

  // Reads follow a pooled sequence when pool_sel is not negative, so k-mers repeat.
  task automatic send_read(input int len, input int pool_sel);
    logic [1:0] code;
    logic [7:0] ch;
    logic       first;
    int         i;
    for (i = 0; i < len; i++) begin
      code = (pool_sel >= 0) ? pool_codes[pool_sel][i] : 2'($urandom);
      case (code)
        CODE_A:  ch = "A";
        CODE_C:  ch = "C";
        CODE_G:  ch = "G";
        default: ch = "T";
      endcase
      if ($urandom_range(1) == 1) ch = ch | 8'h20;
      if ($urandom_range(19) == 0) ch = 8'($urandom);
      first = (i == 0) && ($urandom_range(19) != 0);
      send_item(REQ_BASE, ch, first, 20'($urandom));
    end
  endtask

  task automatic send_query(input int pool_sel);
    logic [19:0] idx;
    int          kk;
    int          st;
    int          j;
    kk  = active_k();
    st  = active_start();
    idx = 20'($urandom);
    if (pool_sel >= 0) begin
      idx = '0;
      for (j = 0; j < kk; j++) idx = {idx[17:0], pool_codes[pool_sel][st - 1 + j]};
      if ($urandom_range(2) == 0) idx = idx | (20'($urandom) << (2 * kk));
    end
    send_item(REQ_QUERY, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic run_phase(input int quota);
    int win;
    int len;
    int base_count;
    win        = active_start() + active_k() - 1;
    base_count = items_sent;
    while (items_sent - base_count < quota) begin
      if ($urandom_range(9) < 8) len = win + $urandom_range(0, 4);
      else len = $urandom_range(1, win + 4);
      send_read(len, ($urandom_range(3) != 0) ? int'($urandom_range(0, READ_POOL - 1)) : -1);
      if ($urandom_range(1) == 1) begin
        send_query(($urandom_range(1) == 1) ? int'($urandom_range(0, READ_POOL - 1)) : -1);
      end
    end
  endtask

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] lead_in [0:11];
    int         t;
    int         i;
    lead_in = '{8'hFF, "C", "G", "T", "a", "c", "g", "t", "N", 8'h00, "T", "g"};
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    req_type_i      <= REQ_BASE;
    base_char_i     <= 8'h00;
    first_of_read_i <= 1'b0;
    query_index_i   <= 20'h00000;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_KMER_LENGTH;
    cfg_data_i      <= 32'd0;
    idle_pct   = 0;
    items_sent = 0;
    cur_k      = KLEN_RESET;
    cur_start  = START_RESET;
    for (t = 0; t < READ_POOL; t++) begin
      for (i = 0; i < POOL_LEN; i++) pool_codes[t][i] = 2'($urandom);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bases before any read start count up from position one.
    for (i = 0; i < 12; i++) send_item(REQ_BASE, lead_in[i], 1'b0, 20'h00000);
    send_item(REQ_QUERY, 8'h00, 1'b0, 20'h6C6C3);
    send_item(REQ_QUERY, 8'hFF, 1'b1, 20'hFFFFF);
    send_item(REQ_QUERY, 8'h00, 1'b0, 20'h00000);

    quiesce();
    program_setting(4'd1, 8'd0, 32'd1);
    send_item(REQ_BASE, "G", 1'b1, 20'h00000);
    send_item(REQ_BASE, "a", 1'b0, 20'hFFFFF);
    send_item(REQ_QUERY, 8'h00, 1'b0, 20'hFFFFE);
    send_item(REQ_QUERY, 8'hFF, 1'b1, 20'h00001);

    quiesce();
    program_setting(4'd0, 8'd1, 32'hFFFF_FFFF);
    send_item(REQ_BASE, "t", 1'b1, 20'h00000);
    send_item(REQ_QUERY, 8'h00, 1'b0, 20'h00003);
    send_item(REQ_QUERY, 8'h00, 1'b0, 20'h00002);

    quiesce();
    idle_pct = 0;
    program_setting(4'd10, 8'd2, 32'd0);
    run_phase(100);

    quiesce();
    idle_pct = 75;
    program_setting(4'd1, 8'd1, 32'd2);
    run_phase(100);

    quiesce();
    idle_pct = 26;
    program_setting(4'd3, 8'd5, 32'd1);
    run_phase(100);

    quiesce();
    idle_pct = 0;
    program_setting(4'd15, 8'd1, 32'd3);
    run_phase(100);

    // The latest start position needs long reads, and one read runs past the position limit.
    quiesce();
    idle_pct = 26;
    program_setting(4'd2, 8'd255, 32'hFFFF_FFFF);
    send_read(515, -1);
    send_query(-1);
    send_read(262, 0);
    repeat (3) send_query(0);
    send_query(-1);

    quiesce();
    idle_pct = 75;
    program_setting(4'd5, 8'd7, $urandom_range(0, 3));
    run_phase(100);

    quiesce();
    idle_pct = 26;
    program_setting(4'd4, 8'd3, 32'd2);
    run_phase(100);

    quiesce();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
